@@ hw/rtl/pps_pkg.sv @@
// shared types and constants for the preemptive priority scheduler
`default_nettype none

package pps_pkg;

  // table geometry
  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  // field widths
  localparam int PRI_W   = 8;
  localparam int BURST_W = 8;
  localparam int ARR_W   = 10;
  localparam int TIME_W  = 13;
  localparam int ID_W    = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // one process slot
  typedef struct packed {
    logic [PRI_W-1:0]   pri;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] rem;
  } entry_t;

  // table write request: full load or remaining-time update
  typedef struct packed {
    logic             load_en;
    logic             dec_en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  // current best candidate of a scan
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } best_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

endpackage

`default_nettype wire

@@ hw/rtl/pps_table.sv @@
// process table: one write port, one scan read port
`default_nettype none

module pps_table (
  input  wire logic                       clk_i,
  input  wire pps_pkg::tbl_wr_t           wr_i,
  input  wire logic [pps_pkg::IDX_W-1:0]  rd_addr_i,
  output pps_pkg::entry_t                 rd_data_o
);

  pps_pkg::entry_t tbl_q [pps_pkg::MAX_PROCS];

  // load a whole slot or update the remaining time of one slot
  always_ff @(posedge clk_i) begin
    if (wr_i.load_en) begin
      tbl_q[wr_i.addr] <= wr_i.data;
    end else if (wr_i.dec_en) begin
      tbl_q[wr_i.addr].rem <= wr_i.data.rem;
    end
  end

  // scan read
  assign rd_data_o = tbl_q[rd_addr_i];

endmodule

`default_nettype wire

@@ hw/rtl/pps_cmp.sv @@
// shared compare unit: keeps the best ready process seen in the current scan
`default_nettype none

module pps_cmp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clear_i,
  input  wire logic                        en_i,
  input  wire logic [pps_pkg::IDX_W-1:0]   idx_i,
  input  wire pps_pkg::entry_t             ent_i,
  input  wire logic [pps_pkg::TIME_W-1:0]  now_i,
  output pps_pkg::best_t                   best_o
);

  logic                        valid_q, valid_d;
  logic [pps_pkg::IDX_W-1:0]   idx_q;
  pps_pkg::entry_t             ent_q;
  logic                        ready;
  logic                        better;

  // arrived, unfinished, and strictly lower priority value than the holder
  assign ready  = (pps_pkg::TIME_W'(ent_i.arr) <= now_i) &&
                  (ent_i.rem != '0);
  assign better = en_i && ready && (!valid_q || (ent_i.pri < ent_q.pri));

  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (better) begin
      valid_d = 1'b1;
    end
  end

  // holder valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // holder payload
  always_ff @(posedge clk_i) begin
    if (!clear_i && better) begin
      idx_q <= idx_i;
      ent_q <= ent_i;
    end
  end

  assign best_o.valid = valid_q;
  assign best_o.idx   = idx_q;
  assign best_o.ent   = ent_q;

endmodule

`default_nettype wire

@@ hw/rtl/preemptive_priority_scheduler_core.sv @@
// top level: load sequencer, tick loop and result register
// a load without last_process_i leaves busy low; a final load starts a run
// each tick scans every loaded process through the compare unit, then applies one update
// a run keeps busy high until its final result is produced
// each result strobes valid_o in the cycle after its update; the receiver cannot stall
// rst_ni clears the sequencer, counters and strobe; table contents are kept
`default_nettype none

module preemptive_priority_scheduler_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [pps_pkg::PRI_W-1:0]    priority_level_i,
  input  wire logic [pps_pkg::BURST_W-1:0]  burst_length_i,
  input  wire logic [pps_pkg::ARR_W-1:0]    arrival_tick_i,
  input  wire logic                         last_process_i,
  output logic                              valid_o,
  output logic [pps_pkg::ID_W-1:0]          process_id_o,
  output logic [pps_pkg::TIME_W-1:0]        completion_tick_o,
  output logic [pps_pkg::TIME_W-1:0]        turnaround_ticks_o,
  output logic [pps_pkg::TIME_W-1:0]        waiting_ticks_o,
  output logic                              last_result_o
);

  pps_pkg::state_e              state_q, state_d;
  logic [pps_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [pps_pkg::CNT_W-1:0]    loaded_q, loaded_d;
  logic [pps_pkg::CNT_W-1:0]    fin_q, fin_d;
  logic [pps_pkg::TIME_W-1:0]   now_q, now_d;

  logic                         valid_q, valid_d;
  logic                         last_q, last_d;
  logic [pps_pkg::ID_W-1:0]     id_q;
  logic [pps_pkg::TIME_W-1:0]   compl_q, turn_q, wait_q;

  pps_pkg::tbl_wr_t             wr;
  pps_pkg::entry_t              rd_ent;
  pps_pkg::best_t               best;
  logic                         cmp_clear;
  logic                         cmp_en;
  logic                         res_load;

  logic                         accept;
  logic [pps_pkg::BURST_W-1:0]  burst_fix;
  logic [pps_pkg::TIME_W-1:0]   now_inc;
  logic [pps_pkg::TIME_W-1:0]   turn;
  logic [pps_pkg::TIME_W-1:0]   wait_t;
  logic [pps_pkg::CNT_W-1:0]    fin_inc;
  logic [pps_pkg::CNT_W-1:0]    id_sum;
  logic                         scan_end;

  pps_table u_table (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_ent)
  );

  pps_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cmp_clear),
    .en_i    (cmp_en),
    .idx_i   (idx_q),
    .ent_i   (rd_ent),
    .now_i   (now_q),
    .best_o  (best)
  );

  // handshake and datapath helpers
  assign busy      = (state_q != pps_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign burst_fix = (burst_length_i == '0) ? pps_pkg::BURST_W'(1) : burst_length_i;
  assign now_inc   = (now_q == pps_pkg::TIME_MAX) ? now_q : now_q + 1'b1;
  assign turn      = now_inc - pps_pkg::TIME_W'(best.ent.arr);
  assign wait_t    = turn - pps_pkg::TIME_W'(best.ent.burst);
  assign fin_inc   = fin_q + 1'b1;
  assign id_sum    = pps_pkg::CNT_W'(best.idx) + 1'b1;
  assign scan_end  = (pps_pkg::CNT_W'(idx_q) + 1'b1) == loaded_q;

  // sequencer: load, scan the table, apply one tick
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    loaded_d  = loaded_q;
    fin_d     = fin_q;
    now_d     = now_q;
    wr        = '0;
    cmp_clear = 1'b0;
    cmp_en    = 1'b0;
    res_load  = 1'b0;
    valid_d   = 1'b0;
    last_d    = 1'b0;

    case (state_q)
      pps_pkg::ST_IDLE: begin
        if (accept) begin
          if (loaded_q < pps_pkg::CNT_W'(pps_pkg::MAX_PROCS)) begin
            wr.load_en     = 1'b1;
            wr.addr        = loaded_q[pps_pkg::IDX_W-1:0];
            wr.data.pri    = priority_level_i;
            wr.data.burst  = burst_fix;
            wr.data.arr    = arrival_tick_i;
            wr.data.rem    = burst_fix;
            loaded_d       = loaded_q + 1'b1;
          end
          if (last_process_i) begin
            state_d   = pps_pkg::ST_SCAN;
            idx_d     = '0;
            now_d     = '0;
            fin_d     = '0;
            cmp_clear = 1'b1;
          end
        end
      end

      pps_pkg::ST_SCAN: begin
        cmp_en = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (scan_end) begin
          state_d = pps_pkg::ST_UPDATE;
        end
      end

      pps_pkg::ST_UPDATE: begin
        now_d     = now_inc;
        cmp_clear = 1'b1;
        idx_d     = '0;
        state_d   = pps_pkg::ST_SCAN;
        if (best.valid) begin
          wr.dec_en   = 1'b1;
          wr.addr     = best.idx;
          wr.data.rem = best.ent.rem - 1'b1;
          if (best.ent.rem == pps_pkg::BURST_W'(1)) begin
            res_load = 1'b1;
            valid_d  = 1'b1;
            fin_d    = fin_inc;
            last_d   = (fin_inc == loaded_q);
            if (fin_inc == loaded_q) begin
              state_d  = pps_pkg::ST_IDLE;
              loaded_d = '0;
            end
          end
        end
      end

      default: begin
        state_d = pps_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pps_pkg::ST_IDLE;
      idx_q    <= '0;
      loaded_q <= '0;
      fin_q    <= '0;
      now_q    <= '0;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      loaded_q <= loaded_d;
      fin_q    <= fin_d;
      now_q    <= now_d;
      valid_q  <= valid_d;
      last_q   <= last_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      id_q    <= pps_pkg::ID_W'(id_sum);
      compl_q <= now_inc;
      turn_q  <= turn;
      wait_q  <= wait_t;
    end
  end

  assign valid_o            = valid_q;
  assign process_id_o       = id_q;
  assign completion_tick_o  = compl_q;
  assign turnaround_ticks_o = turn_q;
  assign waiting_ticks_o    = wait_q;
  assign last_result_o      = last_q;

  // a result only follows an update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == pps_pkg::ST_UPDATE))
    else $error("result strobe without a preceding update");

  // a final load always starts a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_process_i) |=> (state_q == pps_pkg::ST_SCAN))
    else $error("final load did not start a run");

  // the final result closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_result_o) |-> !busy)
    else $error("run still busy after final result");

  // scan index stays within the loaded slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pps_pkg::ST_SCAN) |-> (pps_pkg::CNT_W'(idx_q) < loaded_q))
    else $error("scan index beyond loaded slots");

  // completions never exceed the loaded count during a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (fin_q < loaded_q))
    else $error("completion count overran loaded count");

endmodule

`default_nettype wire
